>>> rtl/core/eic_pkg.sv
// eic_pkg: types and constants of the ethernet ipv4 ingress classifier
// no dependencies; used by the class interface, the top level and the testbench

package eic_pkg;

    typedef enum logic [3:0] {
        CLASS_ARP         = 4'd0,
        CLASS_UDP         = 4'd1,
        CLASS_ICMP        = 4'd2,
        CLASS_IP_OTHER    = 4'd3,
        CLASS_SIM         = 4'd4,
        CLASS_BAD_CKSUM   = 4'd5,
        CLASS_BAD_VERSION = 4'd6,
        CLASS_NOT_OURS    = 4'd7,
        CLASS_OTHER_TYPE  = 4'd8,
        CLASS_SHORT       = 4'd9
    } frame_class_t;

    typedef enum logic [0:0] {
        REG_OWN_IP_ADDRESS = 1'b0,
        REG_OWN_IP_VALID   = 1'b1
    } cfg_index_t;

    localparam int unsigned POS_W   = 5;
    localparam int unsigned SUM_W   = 20;
    localparam int unsigned CFG_W   = 32;

    localparam logic [15:0]      TYPE_ARP   = 16'h0806;
    localparam logic [15:0]      TYPE_IP    = 16'h0800;
    localparam logic [15:0]      TYPE_SIM   = 16'h1000;
    localparam logic [7:0]       VERSION_OK = 8'h45;
    localparam logic [7:0]       PROTO_UDP  = 8'd17;
    localparam logic [7:0]       PROTO_ICMP = 8'd1;
    localparam logic [31:0]      BCAST_ADDR = 32'hffff_ffff;
    localparam logic [POS_W-1:0] POS_TYPE   = 5'd6;
    localparam logic [POS_W-1:0] POS_HDR_LO = 5'd7;
    localparam logic [POS_W-1:0] POS_HDR_HI = 5'd16;
    localparam logic [POS_W-1:0] POS_PROTO  = 5'd11;
    localparam logic [POS_W-1:0] POS_DST_HI = 5'd15;
    localparam logic [POS_W-1:0] POS_LIMIT  = 5'd17;

endpackage

>>> rtl/core/eic_frame_if.sv
// eic_frame_if: request channel carrying frame halfwords into the classifier
// depends on nothing

interface eic_frame_if;

    logic        valid;
    logic        ready;
    logic [15:0] frame_halfword;
    logic        frame_end;

    modport source (output valid, output frame_halfword, output frame_end, input ready);
    modport sink   (input valid, input frame_halfword, input frame_end, output ready);

endinterface

>>> rtl/core/eic_class_if.sv
// eic_class_if: request channel carrying one classification per frame
// depends on eic_pkg for the class code type

interface eic_class_if
    import eic_pkg::*;
;

    logic         valid;
    logic         ready;
    frame_class_t frame_class;
    logic [15:0]  ether_type;
    logic [7:0]   ip_protocol;
    logic [31:0]  ip_destination;

    modport source (output valid, output frame_class, output ether_type,
                    output ip_protocol, output ip_destination, input ready);
    modport sink   (input valid, input frame_class, input ether_type,
                    input ip_protocol, input ip_destination, output ready);

endinterface

>>> rtl/core/eth_ipv4_ingress_classifier.sv
// eth_ipv4_ingress_classifier: top level, ipv4 header check and frame classification
// depends on eic_pkg, eic_frame_if and eic_class_if
//
// usage
//   frame_in takes one 16-bit halfword of an ethernet frame per request, first byte
//   in bits 15 to 8, with frame_end high on the last halfword. halfword 6 is the
//   ethertype, halfwords 7 to 16 the ipv4 header.
//   class_out gives one request per frame, after its last halfword: class code,
//   ethertype, protocol byte and destination address.
//   the configuration port writes the own address (index 0) and its valid flag
//   (index 1); write only while no frame is in flight.
//   a halfword is registered in the input register, then checked and classified
//   combinationally into the result register, from which the result is offered
//   once the last halfword has passed through.
//   throughput: one halfword per cycle unless a held result stalls, set by the single
//   input register stage. reset clears the frame state, the configuration registers
//   and the valid flags of both stages; the block is ready in the first cycle after
//   reset. when class_out stalls the held result waits in its register; halfwords
//   keep flowing until the next last halfword reaches the input register, which then
//   waits for the result register to free.

module eth_ipv4_ingress_classifier
    import eic_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    eic_frame_if.sink            frame_in,
    eic_class_if.source          class_out
);

    logic [31:0]      own_addr_reg;
    logic             own_valid_reg;

    logic             s1_valid_reg;
    logic [15:0]      hw_reg;
    logic             end_reg;

    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [SUM_W-1:0] sum_reg,   sum_next;
    logic [15:0]      type_reg,  type_next;
    logic [7:0]       ver_reg,   ver_next;
    logic [7:0]       proto_reg, proto_next;
    logic [31:0]      dst_reg,   dst_next;

    logic             out_valid_reg, out_valid_next;
    frame_class_t     class_reg,     class_next;
    logic [15:0]      etype_reg;
    logic [7:0]       oproto_reg,    oproto_next;
    logic [31:0]      odst_reg,      odst_next;

    logic             s1_advance;
    logic             out_load;
    logic             in_take;
    logic [SUM_W:0]   folded;
    logic [15:0]      cksum;
    logic             cksum_bad;

    assign s1_advance = s1_valid_reg && (!end_reg || !out_valid_reg || class_out.ready);
    assign out_load   = s1_advance && end_reg;
    assign frame_in.ready = !s1_valid_reg || s1_advance;
    assign in_take    = frame_in.valid && frame_in.ready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg  <= '0;
            own_valid_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_OWN_IP_ADDRESS: own_addr_reg  <= cfg_data;
                REG_OWN_IP_VALID:   own_valid_reg <= cfg_data[0];
                default:            own_valid_reg <= own_valid_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (frame_in.ready)
            s1_valid_reg <= frame_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            hw_reg  <= frame_in.frame_halfword;
            end_reg <= frame_in.frame_end;
        end
    end

    // frame state update with the registered halfword
    always_comb
    begin
        type_next  = type_reg;
        sum_next   = sum_reg;
        ver_next   = ver_reg;
        proto_next = proto_reg;
        dst_next   = dst_reg;
        if (pos_reg == POS_TYPE)
            type_next = hw_reg;
        if (pos_reg >= POS_HDR_LO && pos_reg <= POS_HDR_HI)
            sum_next = sum_reg + {{(SUM_W-16){1'b0}}, hw_reg};
        if (pos_reg == POS_HDR_LO)
            ver_next = hw_reg[15:8];
        if (pos_reg == POS_PROTO)
            proto_next = hw_reg[7:0];
        if (pos_reg == POS_DST_HI)
            dst_next = {hw_reg, dst_reg[15:0]};
        if (pos_reg == POS_HDR_HI)
            dst_next = {dst_reg[31:16], hw_reg};
        pos_next = (pos_reg < POS_LIMIT) ? pos_reg + 5'd1 : POS_LIMIT;
    end

    // header checksum: fold the carry once, complement, all-ones counts as zero
    assign folded    = {1'b0, sum_next} + {{(SUM_W-3){1'b0}}, sum_next[SUM_W-1:16]};
    assign cksum     = ~folded[15:0];
    assign cksum_bad = (cksum != 16'hffff) && (cksum != 16'h0000);

    // classification
    always_comb
    begin
        oproto_next = '0;
        odst_next   = '0;
        if (type_next == TYPE_ARP)
            class_next = CLASS_ARP;
        else if (type_next == TYPE_SIM)
            class_next = CLASS_SIM;
        else if (type_next != TYPE_IP)
            class_next = CLASS_OTHER_TYPE;
        else if (pos_reg < POS_HDR_HI)
            class_next = CLASS_SHORT;
        else
        begin
            oproto_next = proto_next;
            odst_next   = dst_next;
            if (cksum_bad)
                class_next = CLASS_BAD_CKSUM;
            else if (ver_next != VERSION_OK)
                class_next = CLASS_BAD_VERSION;
            else if (dst_next != BCAST_ADDR && own_valid_reg && dst_next != own_addr_reg)
                class_next = CLASS_NOT_OURS;
            else if (proto_next == PROTO_UDP)
                class_next = CLASS_UDP;
            else if (proto_next == PROTO_ICMP)
                class_next = CLASS_ICMP;
            else
                class_next = CLASS_IP_OTHER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            type_reg  <= '0;
            ver_reg   <= '0;
            proto_reg <= '0;
            dst_reg   <= '0;
        end
        else if (out_load)
        begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            type_reg  <= '0;
            ver_reg   <= '0;
            proto_reg <= '0;
            dst_reg   <= '0;
        end
        else if (s1_advance)
        begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            type_reg  <= type_next;
            ver_reg   <= ver_next;
            proto_reg <= proto_next;
            dst_reg   <= dst_next;
        end
    end

    // result register
    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && !class_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            class_reg  <= class_next;
            etype_reg  <= type_next;
            oproto_reg <= oproto_next;
            odst_reg   <= odst_next;
        end
    end

    assign class_out.valid          = out_valid_reg;
    assign class_out.frame_class    = class_reg;
    assign class_out.ether_type     = etype_reg;
    assign class_out.ip_protocol    = oproto_reg;
    assign class_out.ip_destination = odst_reg;

    // checks
    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LIMIT)
        else $error("word position beyond limit");

    a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && end_reg))
        else $error("result without a last halfword");

    a_mid_frame_flows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !end_reg) |-> s1_advance)
        else $error("mid-frame halfword held back");

    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (pos_reg == '0 && sum_reg == '0 && type_reg == '0))
        else $error("frame state not cleared after result");

endmodule

>>> tb/testbench.sv
// testbench: self-checking run of eth_ipv4_ingress_classifier with random frames
// depends on eic_pkg, eic_frame_if, eic_class_if and the classifier top level
// a built-in frame classifier predicts each result; phases vary the filter, idling and stalls
`timescale 1ns / 1ps

module testbench
    import eic_pkg::*;
;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned PHASE_COUNT   = 8;
    localparam int unsigned PHASE_ITEMS   = 220;

    typedef struct {
        logic [15:0] halfword;
        logic        last;
    } halfword_req_t;

    typedef struct {
        frame_class_t cls;
        logic [15:0]  etype;
        logic [7:0]   proto;
        logic [31:0]  dst;
    } class_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    eic_frame_if frame_bus ();
    eic_class_if class_bus ();

    eth_ipv4_ingress_classifier DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame_in  (frame_bus),
        .class_out (class_bus)
    );

    halfword_req_t halfword_backlog[$];
    class_result_t pending_classes[$];
    logic [15:0]   frame_buf[$];

    int unsigned requests_left;
    int unsigned phase_items;
    int unsigned halfwords_sent;
    int unsigned frames_checked;
    int unsigned errors;
    int unsigned cycle_count;
    int unsigned idle_pct;
    int unsigned stall_pct;

    // predictor state
    logic [4:0]  word_pos;
    logic [19:0] hdr_sum;
    logic [15:0] type_cap;
    logic [7:0]  ver_cap;
    logic [7:0]  proto_cap;
    logic [31:0] dst_cap;
    logic [31:0] own_addr;
    logic        own_valid;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_frame_state();
        word_pos  = '0;
        hdr_sum   = '0;
        type_cap  = '0;
        ver_cap   = '0;
        proto_cap = '0;
        dst_cap   = '0;
    endfunction

    function automatic void classify_halfword(input logic [15:0] hw, input logic last);
        logic [4:0]    pos;
        logic [20:0]   folded;
        logic [15:0]   csum;
        class_result_t r;
        pos = word_pos;
        if (pos == POS_TYPE)
            type_cap = hw;
        if (pos >= POS_HDR_LO && pos <= POS_HDR_HI)
            hdr_sum = hdr_sum + {4'b0, hw};
        if (pos == POS_HDR_LO)
            ver_cap = hw[15:8];
        if (pos == POS_PROTO)
            proto_cap = hw[7:0];
        if (pos == POS_DST_HI)
            dst_cap[31:16] = hw;
        if (pos == POS_HDR_HI)
            dst_cap[15:0] = hw;
        word_pos = (pos < POS_LIMIT) ? pos + 5'd1 : POS_LIMIT;
        if (!last)
            return;
        r.etype = type_cap;
        r.proto = '0;
        r.dst   = '0;
        if (type_cap == TYPE_ARP)
            r.cls = CLASS_ARP;
        else if (type_cap == TYPE_SIM)
            r.cls = CLASS_SIM;
        else if (type_cap != TYPE_IP)
            r.cls = CLASS_OTHER_TYPE;
        else if (pos < POS_HDR_HI)
            r.cls = CLASS_SHORT;
        else
        begin
            r.proto = proto_cap;
            r.dst   = dst_cap;
            folded  = {1'b0, hdr_sum} + {17'b0, hdr_sum[19:16]};
            csum    = ~folded[15:0];
            if (csum == 16'hffff)
                csum = '0;
            if (csum != '0)
                r.cls = CLASS_BAD_CKSUM;
            else if (ver_cap != VERSION_OK)
                r.cls = CLASS_BAD_VERSION;
            else if (dst_cap != BCAST_ADDR && own_valid && dst_cap != own_addr)
                r.cls = CLASS_NOT_OURS;
            else if (proto_cap == PROTO_UDP)
                r.cls = CLASS_UDP;
            else if (proto_cap == PROTO_ICMP)
                r.cls = CLASS_ICMP;
            else
                r.cls = CLASS_IP_OTHER;
        end
        pending_classes.push_back(r);
        clear_frame_state();
    endfunction

    function automatic void flush_frame();
        halfword_req_t req;
        foreach (frame_buf[i])
        begin
            req.halfword = frame_buf[i];
            req.last     = (i == frame_buf.size() - 1);
            halfword_backlog.push_back(req);
        end
        requests_left += frame_buf.size();
        phase_items   += frame_buf.size();
        frame_buf.delete();
    endfunction

    function automatic void queue_plain_frame(input logic [15:0] etype, input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            frame_buf.push_back((i == POS_TYPE) ? etype : 16'($urandom));
        flush_frame();
    endfunction

    function automatic void queue_ip_frame(input logic [7:0] proto, input logic [31:0] dst,
                                           input logic [7:0] version, input bit bad_cksum,
                                           input int unsigned payload);
        logic [15:0] hdr[10];
        logic [31:0] acc;
        for (int i = 0; i < 10; i++)
            hdr[i] = 16'($urandom);
        hdr[0] = {version, hdr[0][7:0]};
        hdr[4] = {hdr[4][15:8], proto};
        hdr[5] = '0;
        hdr[8] = dst[31:16];
        hdr[9] = dst[15:0];
        acc = '0;
        for (int i = 0; i < 10; i++)
            acc += {16'b0, hdr[i]};
        while (acc[31:16] != '0)
            acc = {16'b0, acc[15:0]} + {16'b0, acc[31:16]};
        hdr[5] = ~acc[15:0];
        if (bad_cksum)
            hdr[5] ^= 16'($urandom_range(1, 16'hffff));
        for (int i = 0; i < 6; i++)
            frame_buf.push_back(16'($urandom));
        frame_buf.push_back(TYPE_IP);
        for (int i = 0; i < 10; i++)
            frame_buf.push_back(hdr[i]);
        for (int unsigned i = 0; i < payload; i++)
            frame_buf.push_back(16'($urandom));
        flush_frame();
    endfunction

    function automatic void queue_random_frame();
        int unsigned roll;
        logic [7:0]  proto;
        logic [31:0] dst;
        logic [7:0]  version;
        int unsigned payload;
        roll = $urandom_range(99);
        if (roll < 62)
        begin
            case ($urandom_range(2))
                0: proto = PROTO_UDP;
                1: proto = PROTO_ICMP;
                default: proto = 8'($urandom);
            endcase
            case ($urandom_range(2))
                0: dst = BCAST_ADDR;
                1: dst = own_addr;
                default: dst = $urandom;
            endcase
            version = ($urandom_range(9) == 0) ? 8'($urandom) : VERSION_OK;
            payload = ($urandom_range(19) == 0) ? $urandom_range(10, 30) : $urandom_range(6);
            queue_ip_frame(proto, dst, version, $urandom_range(9) == 0, payload);
        end
        else if (roll < 70)
            queue_plain_frame(TYPE_ARP, $urandom_range(7, 19));
        else if (roll < 76)
            queue_plain_frame(TYPE_SIM, $urandom_range(7, 19));
        else if (roll < 84)
            queue_plain_frame(16'($urandom), $urandom_range(7, 24));
        else if (roll < 90)
            queue_plain_frame(TYPE_IP, $urandom_range(7, 16));
        else if (roll < 95)
            queue_plain_frame(16'($urandom), $urandom_range(1, 6));
        else
            queue_plain_frame(TYPE_IP, $urandom_range(17, 24));
    endfunction

    task automatic program_filter(input logic [31:0] addr, input logic valid_flag);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_OWN_IP_ADDRESS;
        cfg_data  <= addr;
        @(posedge clk);
        cfg_index <= REG_OWN_IP_VALID;
        cfg_data  <= {{(CFG_W-1){1'b0}}, valid_flag};
        @(posedge clk);
        cfg_we    <= 1'b0;
        own_addr  = addr;
        own_valid = valid_flag;
    endtask

    task automatic drain();
        while (requests_left != 0 || pending_classes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // halfword request driver
    always @(posedge clk or negedge rst_n)
    begin : halfword_driver
        halfword_req_t req;
        bit accepted;
        if (!rst_n)
        begin
            frame_bus.valid          <= 1'b0;
            frame_bus.frame_halfword <= '0;
            frame_bus.frame_end      <= 1'b0;
        end
        else
        begin
            accepted = frame_bus.valid && frame_bus.ready;
            if (accepted)
            begin
                classify_halfword(frame_bus.frame_halfword, frame_bus.frame_end);
                requests_left--;
                halfwords_sent++;
            end
            if (!frame_bus.valid || accepted)
            begin
                if (halfword_backlog.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    req = halfword_backlog.pop_front();
                    frame_bus.valid          <= 1'b1;
                    frame_bus.frame_halfword <= req.halfword;
                    frame_bus.frame_end      <= req.last;
                end
                else
                    frame_bus.valid <= 1'b0;
            end
        end
    end

    // class result monitor
    always @(posedge clk or negedge rst_n)
    begin : class_monitor
        class_result_t exp_r;
        if (!rst_n)
            class_bus.ready <= 1'b0;
        else
        begin
            if (class_bus.valid && class_bus.ready)
            begin
                if (pending_classes.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result class %0d type %h proto %h dst %h", $time,
                             class_bus.frame_class, class_bus.ether_type,
                             class_bus.ip_protocol, class_bus.ip_destination);
                end
                else
                begin
                    exp_r = pending_classes.pop_front();
                    frames_checked++;
                    if (class_bus.frame_class !== exp_r.cls)
                    begin
                        errors++;
                        $display("%0t: frame_class expected %0d actual %0d", $time,
                                 exp_r.cls, class_bus.frame_class);
                    end
                    if (class_bus.ether_type !== exp_r.etype)
                    begin
                        errors++;
                        $display("%0t: ether_type expected %h actual %h", $time,
                                 exp_r.etype, class_bus.ether_type);
                    end
                    if (class_bus.ip_protocol !== exp_r.proto)
                    begin
                        errors++;
                        $display("%0t: ip_protocol expected %h actual %h", $time,
                                 exp_r.proto, class_bus.ip_protocol);
                    end
                    if (class_bus.ip_destination !== exp_r.dst)
                    begin
                        errors++;
                        $display("%0t: ip_destination expected %h actual %h", $time,
                                 exp_r.dst, class_bus.ip_destination);
                    end
                end
            end
            class_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d requests and %0d results outstanding", $time,
                     requests_left, pending_classes.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] plan_addr;
        logic        plan_valid;
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = REG_OWN_IP_ADDRESS;
        cfg_data                 = '0;
        frame_bus.valid          = 1'b0;
        frame_bus.frame_halfword = '0;
        frame_bus.frame_end      = 1'b0;
        class_bus.ready          = 1'b0;
        requests_left            = 0;
        phase_items              = 0;
        halfwords_sent           = 0;
        frames_checked           = 0;
        errors                   = 0;
        cycle_count              = 0;
        idle_pct                 = 0;
        stall_pct                = 0;
        own_addr                 = '0;
        own_valid                = 1'b0;
        clear_frame_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed frames: runts at both extremes, a minimal arp and a minimal udp frame
        frame_buf.push_back(16'h0000);
        flush_frame();
        frame_buf.push_back(16'hffff);
        flush_frame();
        queue_plain_frame(TYPE_ARP, 7);
        queue_ip_frame(PROTO_UDP, BCAST_ADDR, VERSION_OK, 1'b0, 0);
        drain();

        for (int unsigned p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: begin plan_addr = '0;           plan_valid = 1'b0; end
                1: begin plan_addr = $urandom;     plan_valid = 1'b1; end
                2: begin plan_addr = 32'hffffffff; plan_valid = 1'b1; end
                3: begin plan_addr = '0;           plan_valid = 1'b1; end
                4: begin plan_addr = $urandom;     plan_valid = 1'b0; end
                5: begin plan_addr = $urandom;     plan_valid = 1'b1; end
                6: begin plan_addr = 32'hffffffff; plan_valid = 1'b0; end
                default: begin plan_addr = $urandom; plan_valid = 1'b1; end
            endcase
            if (p != 0)
                program_filter(plan_addr, plan_valid);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                queue_random_frame();
            drain();
        end

        if (pending_classes.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, pending_classes.size());
        end
        $display("%0d halfwords sent, %0d frame results checked across %0d filter settings",
                 halfwords_sent, frames_checked, PHASE_COUNT);
        $display("%0d mismatches", errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
